@@ rtl/urcs_pkg.sv @@
// Shared types and constants for the UART receive checker with LIFO byte store.
// No dependencies; used by every module under rtl/ except urcs_store_mem.
package urcs_pkg;

    localparam int STORE_DEPTH_DEF = 32;

    localparam int OPCODE_W  = 3;
    localparam int STATUS_W  = 3;
    localparam int PMODE_W   = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 2;
    localparam int COUNT_W   = 16;
    localparam int CSEL_W    = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_RECEIVE      = 3'd0,
        OP_POP          = 3'd1,
        OP_CLEAR_STORE  = 3'd2,
        OP_CLEAR_COUNTS = 3'd3,
        OP_READ_COUNT   = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_FRAMING = 3'd1,
        ST_OVERRUN = 3'd2,
        ST_PARITY  = 3'd3,
        ST_FULL    = 3'd4
    } status_t;

    typedef enum logic [PMODE_W-1:0] {
        PAR_NONE   = 2'd0,
        PAR_EVEN   = 2'd1,
        PAR_ODD    = 2'd2,
        PAR_UNUSED = 2'd3
    } parity_mode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_PARITY_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_ERRORS = 1'd1;

    localparam logic [CSEL_W-1:0] CNT_FRAMING = 2'd0;
    localparam logic [CSEL_W-1:0] CNT_OVERRUN = 2'd1;
    localparam logic [CSEL_W-1:0] CNT_PARITY  = 2'd2;
    localparam logic [CSEL_W-1:0] CNT_FULL    = 2'd3;

    // One flag per error kind detected on a receive request
    typedef struct packed {
        logic framing;
        logic overrun;
        logic parity;
        logic full;
    } err_flags_t;

endpackage

@@ rtl/urcs_store_mem.sv @@
// Byte store: single write port, single registered read port.
// Depends on nothing beyond its parameters.
module urcs_store_mem #(
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/urcs_rx_check.sv @@
// Receive checker: parity, line flags and store-full test, status priority.
// Depends on urcs_pkg.
module urcs_rx_check (
    input  logic [urcs_pkg::PMODE_W-1:0]  parity_mode,
    input  logic [7:0]                    data,
    input  logic                          ninth_bit,
    input  logic                          framing_error,
    input  logic                          overrun_error,
    input  logic                          store_full,
    output urcs_pkg::err_flags_t          errors,
    output urcs_pkg::status_t             status
);

    logic expect_bit;
    logic check_on;

    always_comb
    begin
        expect_bit = ^data;
        check_on   = 1'b0;
        case (urcs_pkg::parity_mode_t'(parity_mode))
            urcs_pkg::PAR_EVEN: check_on = 1'b1;
            urcs_pkg::PAR_ODD:
            begin
                check_on   = 1'b1;
                expect_bit = ~(^data);
            end
            default: check_on = 1'b0;
        endcase

        errors.framing = framing_error;
        errors.overrun = overrun_error;
        errors.parity  = check_on && (expect_bit != ninth_bit);
        errors.full    = store_full;

        // last detected error wins
        status = urcs_pkg::ST_OK;
        if (errors.framing) status = urcs_pkg::ST_FRAMING;
        if (errors.overrun) status = urcs_pkg::ST_OVERRUN;
        if (errors.parity)  status = urcs_pkg::ST_PARITY;
        if (errors.full)    status = urcs_pkg::ST_FULL;
    end

endmodule

@@ rtl/urcs_err_counters.sv @@
// Four 16-bit wrapping error counters with bulk clear and a select mux.
// Depends on urcs_pkg.
module urcs_err_counters (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          inc_en,
    input  urcs_pkg::err_flags_t          inc,
    input  logic                          clear,
    input  logic [urcs_pkg::CSEL_W-1:0]   sel,
    output logic [urcs_pkg::COUNT_W-1:0]  value
);

    logic [urcs_pkg::COUNT_W-1:0] cnt_reg  [4];
    logic [urcs_pkg::COUNT_W-1:0] cnt_next [4];
    logic [3:0]                   bump;

    always_comb
    begin
        bump[urcs_pkg::CNT_FRAMING] = inc.framing;
        bump[urcs_pkg::CNT_OVERRUN] = inc.overrun;
        bump[urcs_pkg::CNT_PARITY]  = inc.parity;
        bump[urcs_pkg::CNT_FULL]    = inc.full;
        for (int i = 0; i < 4; i++)
        begin
            cnt_next[i] = cnt_reg[i];
            if (clear)
            begin
                cnt_next[i] = '0;
            end
            else if (inc_en && bump[i])
            begin
                cnt_next[i] = cnt_reg[i] + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    assign value = cnt_reg[sel];

endmodule

@@ rtl/uart_rx_check_stack_buffer.sv @@
// UART receive checker in front of a LIFO byte store with RTS flow control.
// Depends on urcs_pkg, urcs_store_mem, urcs_rx_check, urcs_err_counters.
//
// Each request carries one operation (receive, pop, clear store, clear
// counters, read counter) and returns exactly one response. A request is
// taken every cycle while the response register is free or being drained,
// so the sustained rate is one request per clock, and the response is
// registered at the accepting edge: fill level, RTS and counters update there
// and the pop read goes through the store's registered read port in that same
// edge, landing together with the rest of the response. in_stall is high
// only while a response is held by out_stall. A receive with no error
// pushes its byte; framing, overrun, parity and full errors are each counted
// (when count_errors is set) and the last one in that order is reported.
// RTS rises once two or fewer slots remain after a push and falls on a pop
// that starts with more than two free. Configuration writes are taken at
// any edge with cfg_we high and apply to the next request.
module uart_rx_check_stack_buffer #(
    parameter int STORE_DEPTH = urcs_pkg::STORE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // request channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [urcs_pkg::OPCODE_W-1:0]    opcode,
    input  logic [7:0]                       rx_byte,
    input  logic                             rx_ninth_bit,
    input  logic                             framing_error,
    input  logic                             overrun_error,
    input  logic [urcs_pkg::CSEL_W-1:0]      counter_index,
    // response channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [urcs_pkg::STATUS_W-1:0]    status,
    output logic [7:0]                       read_byte,
    output logic                             store_empty,
    output logic                             store_full,
    output logic                             rts_level,
    output logic [urcs_pkg::COUNT_W-1:0]     counter_value,
    // configuration
    input  logic                             cfg_we,
    input  logic [urcs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [urcs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int FW = $clog2(STORE_DEPTH + 1);
    localparam int AW = $clog2(STORE_DEPTH);
    localparam logic [FW-1:0] DEPTH_F    = FW'(STORE_DEPTH);
    localparam logic [FW-1:0] DEPTH_M2_F = FW'(STORE_DEPTH - 2);
    localparam logic [FW-1:0] DEPTH_M3_F = FW'(STORE_DEPTH - 3);

    // configuration
    logic [urcs_pkg::PMODE_W-1:0] parity_mode_reg;
    logic                         count_errors_reg;

    // stack state
    logic [FW-1:0] fill_reg, fill_next;
    logic          rts_reg, rts_next;

    // response register
    logic                        out_valid_reg, out_valid_next;
    urcs_pkg::status_t           status_reg;
    logic                        pop_hit_reg;
    logic                        empty_reg;
    logic                        full_reg;
    logic [urcs_pkg::COUNT_W-1:0] cval_reg;

    logic                         accept;
    urcs_pkg::op_t                op;
    urcs_pkg::err_flags_t         errs;
    urcs_pkg::status_t            chk_status;
    logic                         is_full;
    logic                         mem_we, mem_re;
    logic [AW-1:0]                mem_raddr;
    logic [7:0]                   mem_rdata;
    logic                         cnt_inc_en, cnt_clear;
    logic [urcs_pkg::COUNT_W-1:0] cnt_value;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;
    assign op       = urcs_pkg::op_t'(opcode);
    assign is_full  = (fill_reg >= DEPTH_F);
    assign mem_raddr = AW'(fill_reg - 1'b1);

    urcs_rx_check u_check (
        .parity_mode   (parity_mode_reg),
        .data          (rx_byte),
        .ninth_bit     (rx_ninth_bit),
        .framing_error (framing_error),
        .overrun_error (overrun_error),
        .store_full    (is_full),
        .errors        (errs),
        .status        (chk_status)
    );

    urcs_store_mem #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (rx_byte),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    urcs_err_counters u_counters (
        .clk    (clk),
        .rst_n  (rst_n),
        .inc_en (cnt_inc_en),
        .inc    (errs),
        .clear  (cnt_clear),
        .sel    (counter_index),
        .value  (cnt_value)
    );

    // operation decode: stack pointer, RTS and store port control
    always_comb
    begin
        fill_next  = fill_reg;
        rts_next   = rts_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        cnt_inc_en = 1'b0;
        cnt_clear  = 1'b0;
        if (accept)
        begin
            case (op)
                urcs_pkg::OP_RECEIVE:
                begin
                    cnt_inc_en = count_errors_reg;
                    if (chk_status == urcs_pkg::ST_OK)
                    begin
                        mem_we    = 1'b1;
                        fill_next = fill_reg + 1'b1;
                        // two or fewer slots left after this push
                        if (fill_reg >= DEPTH_M3_F)
                        begin
                            rts_next = 1'b1;
                        end
                    end
                end
                urcs_pkg::OP_POP:
                begin
                    if (fill_reg < DEPTH_M2_F)
                    begin
                        rts_next = 1'b0;
                    end
                    if (fill_reg != '0)
                    begin
                        fill_next = fill_reg - 1'b1;
                        mem_re    = 1'b1;
                    end
                end
                urcs_pkg::OP_CLEAR_STORE:  fill_next = '0;
                urcs_pkg::OP_CLEAR_COUNTS: cnt_clear = 1'b1;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_mode_reg  <= '0;
            count_errors_reg <= 1'b0;
            fill_reg         <= '0;
            rts_reg          <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    urcs_pkg::CFG_PARITY_MODE:  parity_mode_reg  <= cfg_data;
                    urcs_pkg::CFG_COUNT_ERRORS: count_errors_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            fill_reg      <= fill_next;
            rts_reg       <= rts_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg  <= (op == urcs_pkg::OP_RECEIVE) ? chk_status : urcs_pkg::ST_OK;
            pop_hit_reg <= mem_re;
            empty_reg   <= (fill_next == '0);
            full_reg    <= (fill_next >= DEPTH_F);
            cval_reg    <= (op == urcs_pkg::OP_READ_COUNT) ? cnt_value : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign read_byte     = pop_hit_reg ? mem_rdata : 8'd0;
    assign store_empty   = empty_reg;
    assign store_full    = full_reg;
    assign rts_level     = rts_reg;
    assign counter_value = cval_reg;

    // stack pointer never passes the store depth
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DEPTH_F)
        else $error("fill level beyond store depth");

    // a response cannot report an empty and a full store together
    a_empty_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(empty_reg && full_reg))
        else $error("store reported empty and full at once");

    // an error status only comes from a receive, which returns no byte or count
    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != urcs_pkg::ST_OK) |->
            (!pop_hit_reg && cval_reg == '0))
        else $error("error status with pop or counter data");

    // a push only ever happens on a receive that found room
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> (fill_reg == $past(fill_reg) + 1'b1))
        else $error("push did not advance the stack pointer");

endmodule
